// ===== rtl/core/crfp_pkg.sv =====
// Package for the CRC-16 reply frame parser.
// Holds the parse phase type, the result word type and the nibble-wise CRC functions.
// No dependencies.
package crfp_pkg;

    localparam logic [7:0]  HEADER_BYTE = 8'hFF;
    localparam logic [15:0] CRC_INIT    = 16'hFFFF;

    typedef enum logic [2:0] {
        PH_HEADER  = 3'd0,
        PH_LEN     = 3'd1,
        PH_CMD     = 3'd2,
        PH_STAT_HI = 3'd3,
        PH_STAT_LO = 3'd4,
        PH_DATA    = 3'd5,
        PH_CRC_HI  = 3'd6,
        PH_CRC_LO  = 3'd7
    } t_phase;

    typedef struct packed {
        logic        data_valid;
        logic [7:0]  data_out;
        logic [7:0]  data_index;
        logic        frame_end;
        logic        crc_match;
        logic        ready_flag;
        logic        error_flag;
        logic [7:0]  reply_command;
        logic [15:0] reply_status;
        logic [7:0]  reply_length;
    } t_result;

    // Carry-less product of a nibble with the polynomial 0x1021.
    function automatic logic [15:0] nib_tab(input logic [3:0] k);
        logic [15:0] p;
        p = 16'h0000;
        if (k[0]) p = p ^ 16'h1021;
        if (k[1]) p = p ^ 16'h2042;
        if (k[2]) p = p ^ 16'h4084;
        if (k[3]) p = p ^ 16'h8108;
        return p;
    endfunction

    function automatic logic [15:0] nib_step(input logic [15:0] crc, input logic [3:0] nib);
        return {crc[11:0], nib} ^ nib_tab(crc[15:12]);
    endfunction

    // High nibble goes in first.
    function automatic logic [15:0] crc_byte(input logic [15:0] crc, input logic [7:0] b);
        return nib_step(nib_step(crc, b[7:4]), b[3:0]);
    endfunction

endpackage

// ===== rtl/core/crfp_if.sv =====
// Valid/ready channel interfaces for the reply frame parser.
// Depends on crfp_pkg for the result word type.
interface crfp_in_if;
    logic       valid;
    logic       ready;
    logic       req_type;
    logic [7:0] rx_byte;

    modport source (output valid, output req_type, output rx_byte, input ready);
    modport sink   (input valid, input req_type, input rx_byte, output ready);
endinterface

interface crfp_out_if;
    logic                 valid;
    logic                 ready;
    crfp_pkg::t_result    result;

    modport source (output valid, output result, input ready);
    modport sink   (input valid, input result, output ready);
endinterface

// ===== rtl/core/crc16_reply_frame_parser_unit.sv =====
// Latency: a result word is valid in the cycle after its input word is accepted.
// Throughput: one word per cycle; the input is taken whenever the output register
// is empty or is being emptied in the same cycle, so one register parts both sides.
// Reset: synchronous, active low; clears the parse state, the flags and the output
// valid. A clear request on the input channel has the same effect on the parse state.
module crc16_reply_frame_parser_unit (
    input  logic            i_clk,
    input  logic            i_rst_n,
    crfp_in_if.sink         i_in,
    crfp_out_if.source      o_out
);
    import crfp_pkg::*;

    t_phase      r_phase, n_phase;
    logic [15:0] r_crc, n_crc;
    logic [7:0]  r_len, n_len;
    logic [7:0]  r_count, n_count;
    logic [7:0]  r_cmd, n_cmd;
    logic [15:0] r_status, n_status;
    logic [7:0]  r_crc_hi, n_crc_hi;
    logic        r_ready_bit, n_ready_bit;
    logic        r_error_bit, n_error_bit;
    logic        r_out_valid;
    t_result     r_out, n_out;

    logic        in_fire;
    logic [8:0]  next_index;
    logic        crc_equal;
    logic [15:0] crc_upd;

    assign i_in.ready   = !r_out_valid || o_out.ready;
    assign in_fire      = i_in.valid && i_in.ready;
    assign o_out.valid  = r_out_valid;
    assign o_out.result = r_out;

    assign next_index = {1'b0, r_count} + 9'd1;
    assign crc_equal  = ({r_crc_hi, i_in.rx_byte} == r_crc);
    assign crc_upd    = crc_byte(r_crc, i_in.rx_byte);

    // Next phase.
    always_comb begin
        n_phase = r_phase;
        if (in_fire) begin
            if (i_in.req_type) begin
                n_phase = PH_HEADER;
            end else begin
                unique case (r_phase)
                    PH_HEADER:  if (i_in.rx_byte == HEADER_BYTE) n_phase = PH_LEN;
                    PH_LEN:     n_phase = PH_CMD;
                    PH_CMD:     n_phase = PH_STAT_HI;
                    PH_STAT_HI: n_phase = PH_STAT_LO;
                    PH_STAT_LO: n_phase = (r_len == 8'd0) ? PH_CRC_HI : PH_DATA;
                    PH_DATA:    if (next_index >= {1'b0, r_len}) n_phase = PH_CRC_HI;
                    PH_CRC_HI:  n_phase = PH_CRC_LO;
                    PH_CRC_LO:  n_phase = PH_HEADER;
                    default:    n_phase = PH_HEADER;
                endcase
            end
        end
    end

    // Datapath and result word.
    always_comb begin
        n_crc       = r_crc;
        n_len       = r_len;
        n_count     = r_count;
        n_cmd       = r_cmd;
        n_status    = r_status;
        n_crc_hi    = r_crc_hi;
        n_ready_bit = r_ready_bit;
        n_error_bit = r_error_bit;
        n_out       = '0;
        if (in_fire) begin
            if (i_in.req_type) begin
                n_crc       = CRC_INIT;
                n_len       = 8'd0;
                n_count     = 8'd0;
                n_cmd       = 8'd0;
                n_status    = 16'd0;
                n_crc_hi    = 8'd0;
                n_ready_bit = 1'b0;
                n_error_bit = 1'b0;
            end else begin
                unique case (r_phase)
                    PH_HEADER: begin
                        if (i_in.rx_byte == HEADER_BYTE) begin
                            n_crc       = CRC_INIT;
                            n_count     = 8'd0;
                            n_error_bit = 1'b0;
                        end
                    end
                    PH_LEN: begin
                        n_crc = crc_upd;
                        n_len = i_in.rx_byte;
                    end
                    PH_CMD: begin
                        n_crc = crc_upd;
                        n_cmd = i_in.rx_byte;
                    end
                    PH_STAT_HI: begin
                        n_crc    = crc_upd;
                        n_status = {i_in.rx_byte, 8'd0};
                    end
                    PH_STAT_LO: begin
                        n_crc    = crc_upd;
                        n_status = {r_status[15:8], i_in.rx_byte};
                        n_count  = 8'd0;
                    end
                    PH_DATA: begin
                        n_crc            = crc_upd;
                        n_count          = next_index[7:0];
                        n_out.data_valid = 1'b1;
                        n_out.data_out   = i_in.rx_byte;
                        n_out.data_index = r_count;
                    end
                    PH_CRC_HI: begin
                        n_crc_hi = i_in.rx_byte;
                    end
                    PH_CRC_LO: begin
                        n_out.frame_end = 1'b1;
                        n_out.crc_match = crc_equal;
                        if (crc_equal) n_ready_bit = 1'b1;
                        else           n_error_bit = 1'b1;
                    end
                    default: begin
                        n_crc = r_crc;
                    end
                endcase
            end
        end
        n_out.ready_flag    = n_ready_bit;
        n_out.error_flag    = n_error_bit;
        n_out.reply_command = n_cmd;
        n_out.reply_status  = n_status;
        n_out.reply_length  = n_len;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase     <= PH_HEADER;
            r_crc       <= CRC_INIT;
            r_len       <= 8'd0;
            r_count     <= 8'd0;
            r_cmd       <= 8'd0;
            r_status    <= 16'd0;
            r_crc_hi    <= 8'd0;
            r_ready_bit <= 1'b0;
            r_error_bit <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_phase     <= n_phase;
            r_crc       <= n_crc;
            r_len       <= n_len;
            r_count     <= n_count;
            r_cmd       <= n_cmd;
            r_status    <= n_status;
            r_crc_hi    <= n_crc_hi;
            r_ready_bit <= n_ready_bit;
            r_error_bit <= n_error_bit;
            if (in_fire) begin
                r_out_valid <= 1'b1;
            end else if (o_out.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_fire) begin
            r_out <= n_out;
        end
    end

endmodule
